/* hdl/jkb_pkg.sv */
// Shared types, constants and decode functions for the keyed base64 stream decoder.
`default_nettype none
package jkb_pkg;

    localparam int unsigned KEY_LEN = 6;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [5:0] SEXT_PLUS  = 6'd62;
    localparam logic [5:0] SEXT_SLASH = 6'd63;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       payload_end;
        logic       last;
    } t_res;

    // up to three results caused by one character
    typedef struct packed {
        logic [1:0] cnt;
        t_res       res2;
        t_res       res1;
        t_res       res0;
    } t_grp;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sext;

    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = CH_QUOTE;
            3'd1: ch = 8'h64;
            3'd2: ch = 8'h61;
            3'd3: ch = 8'h74;
            3'd4: ch = 8'h61;
            3'd5: ch = CH_QUOTE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_sext sextet_of(input logic [7:0] c);
        t_sext s;
        s.ok  = 1'b1;
        s.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = SEXT_PLUS;
        end else if (c == 8'h2F) begin
            s.val = SEXT_SLASH;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

/* hdl/jkb_if.sv */
// Valid/ready channel interfaces for characters in and decoded results out.
`default_nettype none
interface jkb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_over;

    modport source (output valid, output char_code, output start_over, input ready);
    modport sink   (input valid, input char_code, input start_over, output ready);
endinterface

interface jkb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       payload_end;
    logic       last;

    modport source (output valid, output data_byte, output byte_valid,
                    output payload_end, output last, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input payload_end, input last, output ready);
endinterface
`default_nettype wire

/* hdl/json_keyed_base64_stream_decoder_core.sv */
// Top level: finds the "data" key, base64-decodes its string value and streams the bytes.
// A character's result group, if it has results, is written into the result queue on its transaction.
// Throughput: one character per cycle while the result queue has room; one result per cycle
// out while o_out.ready, up to three results per character, queue depth QUEUE_DEPTH groups.
// Reset: synchronous active-low i_rst_n returns to key search and empties the queue.
`default_nettype none
module json_keyed_base64_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jkb_in_if.sink    i_in,
    jkb_out_if.source o_out
);

    logic          push;
    logic          space;
    jkb_pkg::t_grp grp;

    jkb_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_space (space),
        .o_push  (push),
        .o_grp   (grp)
    );

    jkb_emit #(
        .DEPTH (QUEUE_DEPTH)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (grp),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

/* hdl/jkb_parse.sv */
// Key matcher, colon/quote tracker and sextet collector; builds one result group per character.
`default_nettype none
module jkb_parse (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    jkb_in_if.sink          i_in,
    input  wire logic       i_space,
    output logic            o_push,
    output jkb_pkg::t_grp   o_grp
);

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    t_phase       r_phase, n_phase, e_phase;
    logic [2:0]   r_kp, n_kp, e_kp;
    logic         r_colon, n_colon, e_colon;
    logic [1:0]   r_cnt, n_cnt, e_cnt;
    logic [5:0]   r_store [3];
    logic         wr_en;
    logic [7:0]   c;
    logic [7:0]   b0, b1, b2;
    logic         accept;
    jkb_pkg::t_sext sx;
    jkb_pkg::t_grp  grp;

    assign i_in.ready = i_space;
    assign accept     = i_in.valid && i_space;
    assign c          = i_in.char_code;
    assign sx         = jkb_pkg::sextet_of(c);

    assign b0 = {r_store[0], r_store[1][5:4]};
    assign b1 = {r_store[1][3:0], r_store[2][5:2]};
    assign b2 = {r_store[2][1:0], sx.val};

    always_comb begin
        e_phase = i_in.start_over ? PH_SEARCH : r_phase;
        e_kp    = i_in.start_over ? 3'd0 : r_kp;
        e_colon = i_in.start_over ? 1'b0 : r_colon;
        e_cnt   = i_in.start_over ? 2'd0 : r_cnt;
        n_phase = e_phase;
        n_kp    = e_kp;
        n_colon = e_colon;
        n_cnt   = e_cnt;
        wr_en   = 1'b0;
        grp     = '0;
        case (e_phase)
            PH_SEARCH: begin
                if (e_kp < 3'(jkb_pkg::KEY_LEN)) begin
                    if (c == jkb_pkg::key_char(e_kp)) begin
                        n_kp = e_kp + 3'd1;
                    end else begin
                        n_kp = (c == jkb_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
                    end
                end else if (!e_colon) begin
                    if (c == jkb_pkg::CH_COLON) begin
                        n_colon = 1'b1;
                    end else if (c != jkb_pkg::CH_SPACE && c != jkb_pkg::CH_TAB &&
                                 c != jkb_pkg::CH_LF && c != jkb_pkg::CH_CR) begin
                        n_kp = 3'd0;
                    end
                end else if (c == jkb_pkg::CH_QUOTE) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (c == jkb_pkg::CH_QUOTE) begin
                    n_cnt   = 2'd0;
                    n_phase = PH_DONE;
                    if (e_cnt == 2'd3) begin
                        grp.cnt  = 2'd2;
                        grp.res0 = '{data_byte: b0, byte_valid: 1'b1,
                                     payload_end: 1'b0, last: 1'b0};
                        grp.res1 = '{data_byte: b1, byte_valid: 1'b1,
                                     payload_end: 1'b1, last: 1'b1};
                    end else if (e_cnt == 2'd2) begin
                        grp.cnt  = 2'd1;
                        grp.res0 = '{data_byte: b0, byte_valid: 1'b1,
                                     payload_end: 1'b1, last: 1'b1};
                    end else begin
                        grp.cnt  = 2'd1;
                        grp.res0 = '{data_byte: 8'd0, byte_valid: 1'b0,
                                     payload_end: 1'b1, last: 1'b1};
                    end
                end else if (c != jkb_pkg::CH_PAD && sx.ok) begin
                    if (e_cnt != 2'd3) begin
                        wr_en = 1'b1;
                        n_cnt = e_cnt + 2'd1;
                    end else begin
                        n_cnt    = 2'd0;
                        grp.cnt  = 2'd3;
                        grp.res0 = '{data_byte: b0, byte_valid: 1'b1,
                                     payload_end: 1'b0, last: 1'b0};
                        grp.res1 = '{data_byte: b1, byte_valid: 1'b1,
                                     payload_end: 1'b0, last: 1'b0};
                        grp.res2 = '{data_byte: b2, byte_valid: 1'b1,
                                     payload_end: 1'b0, last: 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_push = accept && (grp.cnt != 2'd0);
    assign o_grp  = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_kp    <= 3'd0;
            r_colon <= 1'b0;
            r_cnt   <= 2'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_kp    <= n_kp;
            r_colon <= n_colon;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_store[e_cnt] <= sx.val;
        end
    end

endmodule
`default_nettype wire

/* hdl/jkb_emit.sv */
// Result group queue and serializer that sends one result per transaction.
`default_nettype none
module jkb_emit #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jkb_pkg::t_grp i_grp,
    output logic               o_space,
    jkb_out_if.source          o_out
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    jkb_pkg::t_grp r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_idx;
    jkb_pkg::t_grp hd;
    jkb_pkg::t_res cur;
    logic          pop, fire;

    assign hd = r_mem[r_rd];

    always_comb begin
        case (r_idx)
            2'd0:    cur = hd.res0;
            2'd1:    cur = hd.res1;
            2'd2:    cur = hd.res2;
            default: cur = hd.res0;
        endcase
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.data_byte   = cur.data_byte;
    assign o_out.byte_valid  = cur.byte_valid;
    assign o_out.payload_end = cur.payload_end;
    assign o_out.last        = cur.last;

    assign fire    = o_out.valid && o_out.ready;
    assign pop     = fire && cur.last;
    assign o_space = (r_cnt != CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_idx <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (pop) begin
                r_idx <= 2'd0;
            end else if (fire) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

endmodule
`default_nettype wire

/* verif/json_keyed_base64_stream_decoder_core_test.sv */
// Testbench for the keyed base64 stream decoder: directed and random JSON frames, scoreboard.
module json_keyed_base64_stream_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    localparam logic [0:5][7:0] KEY_TEXT  = {jkb_pkg::CH_QUOTE, "data", jkb_pkg::CH_QUOTE};
    localparam logic [0:3][7:0] WS_CHARS  = {jkb_pkg::CH_SPACE, jkb_pkg::CH_TAB,
                                             jkb_pkg::CH_LF, jkb_pkg::CH_CR};
    localparam int              IDLE_PCT  = 16;

    logic i_clk;
    logic i_rst_n;

    jkb_in_if  u_in ();
    jkb_out_if u_out ();

    json_keyed_base64_stream_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in.sink),
        .o_out   (u_out.source)
    );

    // decoder state as predicted
    t_phase     ph;
    logic [2:0] key_cnt;
    logic       colon_ok;
    logic [5:0] sx [3];
    logic [1:0] sx_cnt;

    jkb_pkg::t_res decoded_q [$];
    int   err_count;
    int   live_chars;
    bit   no_idle;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        $display("[%0t] mismatch %s: expected %0h got %0h", $time, what, want_v, got_v);
        err_count++;
    endtask

    function automatic jkb_pkg::t_sext b64_value(input logic [7:0] c);
        jkb_pkg::t_sext s;
        s.ok  = 1'b1;
        s.val = 6'd0;
        if (c == "+") begin
            s.val = 6'd62;
        end else if (c == "/") begin
            s.val = 6'd63;
        end else if (c >= "0" && c <= "9") begin
            s.val = 6'(c + 8'd4);
        end else if (c >= "a" && c <= "z") begin
            s.val = 6'(c - 8'd71);
        end else if (c >= "A" && c <= "Z") begin
            s.val = 6'(c - 8'd65);
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26) return 8'(v) + "A";
        if (v < 6'd52) return 8'(v) - 8'd26 + "a";
        if (v < 6'd62) return 8'(v) - 8'd52 + "0";
        return (v == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic bv, input logic pe,
                                      input logic lst);
        jkb_pkg::t_res r;
        r.data_byte   = b;
        r.byte_valid  = bv;
        r.payload_end = pe;
        r.last        = lst;
        decoded_q.push_back(r);
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic so);
        jkb_pkg::t_sext s;
        logic [7:0]     b0;
        logic [7:0]     b1;
        if (so) begin
            ph       = PH_KEY;
            key_cnt  = 3'd0;
            colon_ok = 1'b0;
            sx       = '{default: 6'd0};
            sx_cnt   = 2'd0;
        end
        b0 = {sx[0], sx[1][5:4]};
        b1 = {sx[1][3:0], sx[2][5:2]};
        case (ph)
            PH_KEY: begin
                if (key_cnt < 3'(jkb_pkg::KEY_LEN)) begin
                    if (c == KEY_TEXT[key_cnt]) key_cnt = key_cnt + 3'd1;
                    else key_cnt = (c == jkb_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
                end else if (!colon_ok) begin
                    if (c == jkb_pkg::CH_COLON) colon_ok = 1'b1;
                    else if (c != jkb_pkg::CH_SPACE && c != jkb_pkg::CH_TAB &&
                             c != jkb_pkg::CH_LF && c != jkb_pkg::CH_CR)
                        key_cnt = 3'd0;
                end else if (c == jkb_pkg::CH_QUOTE) begin
                    ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                s = b64_value(c);
                if (c == jkb_pkg::CH_QUOTE) begin
                    if (sx_cnt == 2'd3) begin
                        push_byte(b0, 1'b1, 1'b0, 1'b0);
                        push_byte(b1, 1'b1, 1'b1, 1'b1);
                    end else if (sx_cnt == 2'd2) begin
                        push_byte(b0, 1'b1, 1'b1, 1'b1);
                    end else begin
                        push_byte(8'h00, 1'b0, 1'b1, 1'b1);
                    end
                    sx_cnt = 2'd0;
                    ph     = PH_DONE;
                end else if (c != jkb_pkg::CH_PAD && s.ok) begin
                    if (sx_cnt != 2'd3) begin
                        sx[sx_cnt] = s.val;
                        sx_cnt     = sx_cnt + 2'd1;
                    end else begin
                        push_byte(b0, 1'b1, 1'b0, 1'b0);
                        push_byte(b1, 1'b1, 1'b0, 1'b0);
                        push_byte({sx[2][1:0], s.val}, 1'b1, 1'b0, 1'b1);
                        sx_cnt = 2'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_char(input logic [7:0] c, input logic so);
        int gap;
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
            u_in.valid     <= 1'b0;
            u_in.char_code <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        u_in.valid      <= 1'b1;
        u_in.char_code  <= c;
        u_in.start_over <= so;
        @(posedge i_clk);
        while (!u_in.ready) @(posedge i_clk);
        if (so || ph != PH_DONE) live_chars++;
        decode_char(c, so);
    endtask

    always @(posedge i_clk) begin : result_check
        jkb_pkg::t_res want;
        if (i_rst_n && u_out.valid && u_out.ready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected result, data_byte", 0, u_out.data_byte);
            end else begin
                want = decoded_q.pop_front();
                if (u_out.data_byte !== want.data_byte)
                    report_mismatch("data_byte", want.data_byte, u_out.data_byte);
                if (u_out.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", want.byte_valid, u_out.byte_valid);
                if (u_out.payload_end !== want.payload_end)
                    report_mismatch("payload_end", want.payload_end, u_out.payload_end);
                if (u_out.last !== want.last)
                    report_mismatch("last", want.last, u_out.last);
            end
        end
        u_out.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // quote restart inside the key, all four blanks, junk after colon, opening quote
    task automatic test_key_match();
        send_char(jkb_pkg::CH_QUOTE, 1'b1);
        for (int i = 0; i < jkb_pkg::KEY_LEN; i++) send_char(KEY_TEXT[i], 1'b0);
        for (int i = 0; i < 4; i++) send_char(WS_CHARS[i], 1'b0);
        send_char(jkb_pkg::CH_COLON, 1'b0);
        send_char("x", 1'b0);
        send_char(jkb_pkg::CH_QUOTE, 1'b0);
    endtask

    // full quartet, pad and junk skipped, two-sextet flush, ignored after the end
    task automatic test_payload_decode();
        send_char(8'hFF, 1'b0);
        send_char("+", 1'b0);
        send_char("/", 1'b0);
        send_char("A", 1'b0);
        send_char("z", 1'b0);
        send_char(jkb_pkg::CH_PAD, 1'b0);
        send_char("0", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("9", 1'b0);
        send_char(jkb_pkg::CH_QUOTE, 1'b0);
        send_char("Q", 1'b0);
    endtask

    task automatic send_frame();
        int  bad;
        int  n;
        bit  cut;
        send_char(8'($urandom), ($urandom_range(99) < 85));
        repeat ($urandom_range(0, 2)) send_char(8'($urandom), 1'b0);
        bad = ($urandom_range(99) < 8) ? $urandom_range(0, jkb_pkg::KEY_LEN - 1)
                                        : jkb_pkg::KEY_LEN;
        for (int i = 0; i < jkb_pkg::KEY_LEN; i++)
            send_char((i == bad) ? 8'($urandom) : KEY_TEXT[i], 1'b0);
        repeat ($urandom_range(0, 2)) send_char(WS_CHARS[$urandom_range(0, 3)], 1'b0);
        if ($urandom_range(99) < 6) send_char(8'($urandom), 1'b0);
        send_char(jkb_pkg::CH_COLON, 1'b0);
        repeat ($urandom_range(0, 2)) send_char(8'($urandom), 1'b0);
        send_char(jkb_pkg::CH_QUOTE, 1'b0);
        n   = ($urandom_range(99) < 10) ? $urandom_range(15, 40) : $urandom_range(0, 14);
        cut = 1'b0;
        for (int i = 0; i < n && !cut; i++) begin
            if ($urandom_range(99) < 12)
                send_char(($urandom_range(1) != 0) ? jkb_pkg::CH_PAD : 8'($urandom), 1'b0);
            send_char(b64_char(6'($urandom)), 1'b0);
            cut = ($urandom_range(99) < 4);
        end
        if (!cut) begin
            send_char(jkb_pkg::CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 2)) send_char(8'($urandom), 1'b0);
        end
    endtask

    task automatic test_random_frames();
        int frame_cnt;
        frame_cnt = 0;
        while (live_chars < 195) begin
            no_idle = (frame_cnt >= 3 && frame_cnt < 7);
            send_frame();
            frame_cnt++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int drain;
        err_count       = 0;
        live_chars      = 0;
        no_idle         = 1'b0;
        ph              = PH_KEY;
        key_cnt         = 3'd0;
        colon_ok        = 1'b0;
        sx              = '{default: 6'd0};
        sx_cnt          = 2'd0;
        u_in.valid      = 1'b0;
        u_in.char_code  = 8'h00;
        u_in.start_over = 1'b0;
        u_out.ready     = 1'b0;
        i_rst_n         = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_key_match();
        test_payload_decode();
        test_random_frames();

        u_in.valid <= 1'b0;
        drain = 0;
        while (decoded_q.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (decoded_q.size() != 0)
            report_mismatch("results never delivered, count", 0, decoded_q.size());
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/jkb_pkg.sv
hdl/jkb_if.sv
hdl/jkb_parse.sv
hdl/jkb_emit.sv
hdl/json_keyed_base64_stream_decoder_core.sv
verif/json_keyed_base64_stream_decoder_core_test.sv
